@@ rtl/miniblock_chunk_deframer_unit_assert.svh @@
// Assertion macros shared by the deframer checker.
`ifndef MINIBLOCK_CHUNK_DEFRAMER_UNIT_ASSERT_SVH
`define MINIBLOCK_CHUNK_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define MCDF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// Next-cycle implication, sampled on the rising clock and off during reset.
`define MCDF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

@@ rtl/mcdf_pkg.sv @@
// Types and constants for the chunk deframer.
`default_nettype none

package mcdf_pkg;

	// Parsing phase of the deframer.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_DATA   = 2'd1,
		PH_ALIGN  = 2'd2,
		PH_ERROR  = 2'd3
	} phase_t;

	// Completion status reported with the final payload byte.
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TRUNC   = 3'd1,
		ST_PREFIX  = 3'd2,
		ST_MARKER  = 3'd3,
		ST_EXCEEDS = 3'd4
	} status_t;

	// Header layout.
	localparam logic [7:0] MarkerByte = 8'hFE;
	localparam logic [2:0] HdrLastPos = 3'd7;
	localparam logic [2:0] HdrPrefix0 = 3'd0;
	localparam logic [2:0] HdrPrefix1 = 3'd1;
	localparam logic [2:0] HdrSizeLo  = 3'd2;
	localparam logic [2:0] HdrSizeHi  = 3'd3;
	localparam logic [2:0] HdrMarker0 = 3'd6;

endpackage

`default_nettype wire

@@ rtl/miniblock_chunk_deframer_unit.sv @@
// Chunk deframer: strips 8-byte chunk headers and alignment padding from a byte stream.
// An accepted request is held in the input register; its result, if it has one, is then
// registered in the result register, from which it is taken.
// Throughput: one byte per cycle; the input register and the result register
// both advance whenever the result register is empty or being drained.
// Reset: arst_n asynchronously clears all valid flags and the parsing state
// (header phase, counters zero, no error); payload registers are not reset.
`default_nettype none

module miniblock_chunk_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire logic        s_axis_tlast,   // payload_last
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
	output logic [1:0]       m_axis_tuser,   // [0] has_data, [1] chunk_last
	output logic             m_axis_tlast    // payload_done
);

	// Input stage.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Parsing state.
	mcdf_pkg::phase_t  phase_q, phase_n;
	logic [2:0]        hdr_pos_q, hdr_pos_n;
	logic [7:0]        size_lo_q, size_lo_n;
	logic [15:0]       remain_q, remain_n;
	logic [2:0]        align_q, align_n;
	mcdf_pkg::status_t err_q, err_n;

	// Result of the current request.
	logic              has_data;
	logic [7:0]        obyte;
	logic              clast;
	mcdf_pkg::status_t status;
	logic              emit;

	// Output register.
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [2:0]        out_status_q;
	logic              out_has_q;
	logic              out_clast_q;
	logic              out_done_q;

	logic out_free;
	logic advance;

	// Pipeline flow control.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Next-state logic for the parser.
	always_comb begin
		logic [2:0]  k;
		logic [15:0] rem_dec;
		logic [2:0]  al_inc;
		k         = hdr_pos_q;
		rem_dec   = remain_q - 16'd1;
		al_inc    = align_q + 3'd1;
		phase_n   = phase_q;
		hdr_pos_n = hdr_pos_q;
		size_lo_n = size_lo_q;
		remain_n  = remain_q;
		align_n   = align_q;
		err_n     = err_q;
		case (phase_q)
			mcdf_pkg::PH_HEADER: begin
				if ((k == mcdf_pkg::HdrPrefix0 || k == mcdf_pkg::HdrPrefix1)
				    && byte_s1 != 8'd0) begin
					err_n = mcdf_pkg::ST_PREFIX;
				end else if (k == mcdf_pkg::HdrSizeLo) begin
					size_lo_n = byte_s1;
				end else if (k == mcdf_pkg::HdrSizeHi) begin
					remain_n = {byte_s1, size_lo_q};
				end else if ((k == mcdf_pkg::HdrMarker0 || k == mcdf_pkg::HdrLastPos)
				             && byte_s1 != mcdf_pkg::MarkerByte) begin
					err_n = mcdf_pkg::ST_MARKER;
				end
				hdr_pos_n = k + 3'd1;
				if (err_n != mcdf_pkg::ST_OK) begin
					phase_n = mcdf_pkg::PH_ERROR;
				end else if (k == mcdf_pkg::HdrLastPos) begin
					align_n = 3'd0;
					phase_n = (remain_q != 16'd0) ? mcdf_pkg::PH_DATA : mcdf_pkg::PH_HEADER;
				end
			end
			mcdf_pkg::PH_DATA: begin
				remain_n = rem_dec;
				align_n  = al_inc;
				if (rem_dec == 16'd0) begin
					phase_n = (al_inc != 3'd0) ? mcdf_pkg::PH_ALIGN : mcdf_pkg::PH_HEADER;
				end
			end
			mcdf_pkg::PH_ALIGN: begin
				align_n = al_inc;
				if (al_inc == 3'd0) begin
					phase_n = mcdf_pkg::PH_HEADER;
				end
			end
			default: begin
				// Error kept; finish counting the header in which it arose.
				if (k != 3'd0) begin
					hdr_pos_n = k + 3'd1;
				end
			end
		endcase
		// The final byte returns the parser to its reset state.
		if (advance && last_s1) begin
			phase_n   = mcdf_pkg::PH_HEADER;
			hdr_pos_n = 3'd0;
			size_lo_n = 8'd0;
			remain_n  = 16'd0;
			align_n   = 3'd0;
			err_n     = mcdf_pkg::ST_OK;
		end
	end

	// Result logic for the parser.
	always_comb begin
		logic [2:0] k;
		logic       hdr_err;
		k        = hdr_pos_q;
		hdr_err  = 1'b0;
		has_data = 1'b0;
		obyte    = 8'd0;
		clast    = 1'b0;
		status   = mcdf_pkg::ST_OK;
		case (phase_q)
			mcdf_pkg::PH_HEADER: begin
				hdr_err = ((k == mcdf_pkg::HdrPrefix0 || k == mcdf_pkg::HdrPrefix1)
				           && byte_s1 != 8'd0)
				       || ((k == mcdf_pkg::HdrMarker0 || k == mcdf_pkg::HdrLastPos)
				           && byte_s1 != mcdf_pkg::MarkerByte);
				if (k != mcdf_pkg::HdrLastPos) begin
					status = mcdf_pkg::ST_TRUNC;
				end else if (hdr_err) begin
					status = mcdf_pkg::ST_MARKER;
				end else if (err_q != mcdf_pkg::ST_OK) begin
					status = err_q;
				end else if (remain_q != 16'd0) begin
					status = mcdf_pkg::ST_EXCEEDS;
				end
			end
			mcdf_pkg::PH_DATA: begin
				has_data = 1'b1;
				obyte    = byte_s1;
				clast    = (remain_q == 16'd1);
				status   = (remain_q != 16'd1) ? mcdf_pkg::ST_EXCEEDS : mcdf_pkg::ST_OK;
			end
			mcdf_pkg::PH_ALIGN: begin
				status = mcdf_pkg::ST_OK;
			end
			default: begin
				status = err_q;
				if (k != 3'd0 && k != mcdf_pkg::HdrLastPos) begin
					status = mcdf_pkg::ST_TRUNC;
				end
			end
		endcase
		emit = has_data || last_s1;
	end

	// Parsing state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mcdf_pkg::PH_HEADER;
			hdr_pos_q <= 3'd0;
			size_lo_q <= 8'd0;
			remain_q  <= 16'd0;
			align_q   <= 3'd0;
			err_q     <= mcdf_pkg::ST_OK;
		end else if (advance) begin
			phase_q   <= phase_n;
			hdr_pos_q <= hdr_pos_n;
			size_lo_q <= size_lo_n;
			remain_q  <= remain_n;
			align_q   <= align_n;
			err_q     <= err_n;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_byte_q   <= obyte;
			out_has_q    <= has_data;
			out_clast_q  <= clast;
			out_done_q   <= last_s1;
			out_status_q <= last_s1 ? status : mcdf_pkg::ST_OK;
		end
	end

	// Output packing.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_status_q, out_byte_q};
	assign m_axis_tuser  = {out_clast_q, out_has_q};
	assign m_axis_tlast  = out_done_q;

endmodule

`default_nettype wire

@@ rtl/mcdf_checker.sv @@
// Port-level checker for the chunk deframer and its bind.
`default_nettype none

`include "miniblock_chunk_deframer_unit_assert.svh"

module mcdf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic [18:0] out_bus;
	logic        res_stalled;
	logic        res_nodata;
	logic        nodata_clean;
	logic        status_ok;

	// Result contents and the conditions checked on them.
	assign out_bus      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
	assign res_stalled  = m_axis_tvalid && !m_axis_tready;
	assign res_nodata   = m_axis_tvalid && !m_axis_tuser[0];
	assign nodata_clean = (m_axis_tdata[7:0] == 8'd0) && !m_axis_tuser[1];
	assign status_ok    = (m_axis_tlast || m_axis_tdata[10:8] == mcdf_pkg::ST_OK)
	                   && (m_axis_tdata[15:11] == 5'd0)
	                   && (m_axis_tdata[10:8] <= mcdf_pkg::ST_EXCEEDS);

	// A stalled result keeps its contents.
	`MCDF_ASSERT_NEXT(a_out_hold, res_stalled, m_axis_tvalid && $stable(out_bus))

	// A result without a data byte is only given for the final payload byte.
	`MCDF_ASSERT_NOW(a_nodata_done, res_nodata, m_axis_tlast)

	// Without data, the byte and the chunk end mark are zero.
	`MCDF_ASSERT_NOW(a_nodata_zero, res_nodata, nodata_clean)

	// Status is zero except on the final result, and never above the largest code.
	`MCDF_ASSERT_NOW(a_status_range, m_axis_tvalid, status_ok)

endmodule

bind miniblock_chunk_deframer_unit mcdf_checker u_mcdf_checker (.*);

`default_nettype wire
